// ===== rtl/tpt_state_variable_filter_top_assert.svh =====
// ----------------------------------------------------------------------------
// State variable filter assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef TPT_STATE_VARIABLE_FILTER_TOP_ASSERT_SVH
`define TPT_STATE_VARIABLE_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define TSVF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TSVF_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSVF_ASSERT(label, prop, msg)
`define TSVF_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== rtl/tsvf_pkg.sv =====
// ----------------------------------------------------------------------------
// State variable filter package
// Widths, register indexes, filter modes and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsvf_pkg;

	localparam int DATA_W     = 24;
	localparam int COEF_W     = 24;
	localparam int STATE_W    = 32;
	localparam int VAL_W      = 40;
	localparam int DIGIT_W    = 8;
	localparam int NUM_DIGITS = COEF_W / DIGIT_W;
	localparam int CNT_W      = $clog2(NUM_DIGITS);
	localparam int LOW_W      = NUM_DIGITS * DIGIT_W;
	localparam int PROD_W     = VAL_W + DIGIT_W + 1;
	localparam int ACC_W      = VAL_W + 3;
	localparam int SUM_W      = ACC_W + DIGIT_W;
	localparam int INT_W      = VAL_W + 2;
	localparam int COEF_FRAC  = 22;
	localparam int MORPH_FRAC = 16;
	localparam int MORPH_W    = 17;
	localparam int MORPH_ONE  = 1 << MORPH_FRAC;
	localparam int MORPH_HALF = MORPH_ONE / 2;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [COEF_W-1:0] A1_RST = COEF_W'(4194304);
	localparam logic [COEF_W-1:0] K_RST  = COEF_W'(8388608);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A1      = 3'd0,
		REG_COEF_A2      = 3'd1,
		REG_COEF_A3      = 3'd2,
		REG_DAMPING_K    = 3'd3,
		REG_FILTER_MODE  = 3'd4,
		REG_MORPH_ENABLE = 3'd5,
		REG_MORPH_AMOUNT = 3'd6
	} tsvf_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LP    = 2'd0,
		MODE_BP    = 2'd1,
		MODE_HP    = 2'd2,
		MODE_NOTCH = 2'd3
	} tsvf_mode_t;

	typedef struct packed {
		logic start;
		logic blend;
	} tsvf_mac_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tsvf_mac_sts_t;

endpackage

`default_nettype wire

// ===== rtl/tsvf_mac.sv =====
// ----------------------------------------------------------------------------
// State variable filter digit-serial MAC
// Two-term sum of products, coefficients consumed one digit per cycle, LSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tpt_state_variable_filter_top_assert.svh"

module tsvf_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tsvf_pkg::tsvf_mac_req_t              req,
	input  logic        [tsvf_pkg::COEF_W-1:0]   coef_a,
	input  logic        [tsvf_pkg::COEF_W-1:0]   coef_b,
	input  logic signed [tsvf_pkg::VAL_W-1:0]    op_a,
	input  logic signed [tsvf_pkg::VAL_W-1:0]    op_b,
	output tsvf_pkg::tsvf_mac_sts_t              sts,
	output logic signed [tsvf_pkg::ACC_W-1:0]    acc,
	output logic        [tsvf_pkg::LOW_W-1:0]    low
);

	logic        [tsvf_pkg::COEF_W-1:0]  coef_a_q, coef_b_q;
	logic signed [tsvf_pkg::VAL_W-1:0]   op_a_q, op_b_q;
	logic signed [tsvf_pkg::ACC_W-1:0]   acc_q, acc_init;
	logic        [tsvf_pkg::LOW_W-1:0]   low_q;
	logic        [tsvf_pkg::CNT_W-1:0]   cnt_q;
	logic                                busy_q, done_q;
	logic        [tsvf_pkg::DIGIT_W-1:0] dig_a, dig_b;
	logic signed [tsvf_pkg::PROD_W-1:0]  prod_a, prod_b;
	logic signed [tsvf_pkg::SUM_W-1:0]   sum;

	assign dig_a  = coef_a_q[tsvf_pkg::DIGIT_W-1:0];
	assign dig_b  = coef_b_q[tsvf_pkg::DIGIT_W-1:0];
	assign prod_a = op_a_q * $signed({1'b0, dig_a});
	assign prod_b = op_b_q * $signed({1'b0, dig_b});
	assign sum    = tsvf_pkg::SUM_W'(acc_q) + tsvf_pkg::SUM_W'(prod_a)
	              + tsvf_pkg::SUM_W'(prod_b);

	// rounding constant preloaded at weight 2^0
	assign acc_init = req.blend ? (tsvf_pkg::ACC_W'(1) <<< (tsvf_pkg::MORPH_FRAC - 1))
	                            : (tsvf_pkg::ACC_W'(1) <<< (tsvf_pkg::COEF_FRAC - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == tsvf_pkg::CNT_W'(tsvf_pkg::NUM_DIGITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			coef_a_q <= coef_a;
			coef_b_q <= coef_b;
			op_a_q   <= op_a;
			op_b_q   <= op_b;
			acc_q    <= acc_init;
			low_q    <= '0;
		end else if (busy_q) begin
			coef_a_q <= coef_a_q >> tsvf_pkg::DIGIT_W;
			coef_b_q <= coef_b_q >> tsvf_pkg::DIGIT_W;
			acc_q    <= tsvf_pkg::ACC_W'(sum >>> tsvf_pkg::DIGIT_W);
			low_q    <= {sum[tsvf_pkg::DIGIT_W-1:0], low_q[tsvf_pkg::LOW_W-1:tsvf_pkg::DIGIT_W]};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign acc      = acc_q;
	assign low      = low_q;

	`TSVF_ASSERT(a_mac_start_idle, req.start |-> !busy_q, "MAC started while busy")
	`TSVF_ASSERT(a_mac_done_pulse, done_q |=> !done_q, "MAC done held for two cycles")
	`TSVF_ASSERT(a_mac_cnt_range, busy_q |-> (cnt_q <= tsvf_pkg::CNT_W'(tsvf_pkg::NUM_DIGITS - 1)), "MAC digit count out of range")

endmodule

`default_nettype wire

// ===== rtl/tpt_state_variable_filter_top.sv =====
// ----------------------------------------------------------------------------
// Trapezoidal state variable filter
// LP/BP/HP/notch or LP-BP-HP morph, 24-bit samples, digit-serial shared MAC.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  cfg      | in        | cfg_wr_en            | cfg_index[2:0], cfg_data[23:0]
//  in       | in        | in_valid / in_stall  | sample_in[23:0] signed
//  out      | out       | out_valid / out_stall| sample_out[23:0] signed
//
//  One sample is processed at a time, in three MAC passes, four with morph
//  enabled, each over 3 coefficient digits of 8 bits.
//  A finished sample waits in the output register; the next input is taken
//  while it waits, and the block stalls at the end only if it is still held.
//  Async reset restores register defaults and clears both integrators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tpt_state_variable_filter_top_assert.svh"

module tpt_state_variable_filter_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic        [tsvf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [tsvf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [tsvf_pkg::DATA_W-1:0]     sample_in,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [tsvf_pkg::DATA_W-1:0]     sample_out
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_V1    = 8'b0000_0010,
		S_V2    = 8'b0000_0100,
		S_KV1   = 8'b0000_1000,
		S_HP    = 8'b0001_0000,
		S_SEL   = 8'b0010_0000,
		S_BLEND = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} tsvf_state_t;

	localparam int INT_W = tsvf_pkg::INT_W;

	tsvf_state_t                           state_q;
	logic        [tsvf_pkg::COEF_W-1:0]    a1_q, a2_q, a3_q, k_q;
	tsvf_pkg::tsvf_mode_t                  mode_q;
	logic                                  morph_en_q;
	logic        [tsvf_pkg::MORPH_W-1:0]   morph_q;
	logic signed [tsvf_pkg::STATE_W-1:0]   s1_q, s2_q;
	logic signed [tsvf_pkg::DATA_W-1:0]    x_q, out_q;
	logic signed [tsvf_pkg::VAL_W-1:0]     v3_q, v1_q, v2_q, notch_q, hp_q, y_q;
	logic                                  out_valid_q;

	logic signed [tsvf_pkg::VAL_W-1:0]     v3_in, res_coef, res_blend;
	logic signed [INT_W-1:0]               int1_full, int2_full;
	logic        [tsvf_pkg::MORPH_W-1:0]   m_clip, t_w, w_a;
	logic                                  m_upper;
	logic                                  out_load;

	tsvf_pkg::tsvf_mac_req_t               mac_req;
	tsvf_pkg::tsvf_mac_sts_t               mac_sts;
	logic        [tsvf_pkg::COEF_W-1:0]    mac_coef_a, mac_coef_b;
	logic signed [tsvf_pkg::VAL_W-1:0]     mac_op_a, mac_op_b;
	logic signed [tsvf_pkg::ACC_W-1:0]     mac_acc;
	logic        [tsvf_pkg::LOW_W-1:0]     mac_low;

	function automatic logic signed [tsvf_pkg::STATE_W-1:0] sat_state(
		input logic signed [INT_W-1:0] v
	);
		logic [INT_W-tsvf_pkg::STATE_W:0] top;
		top = v[INT_W-1:tsvf_pkg::STATE_W-1];
		if (top == '0 || top == '1) begin
			return v[tsvf_pkg::STATE_W-1:0];
		end else if (v[INT_W-1]) begin
			return {1'b1, {(tsvf_pkg::STATE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(tsvf_pkg::STATE_W-1){1'b1}}};
		end
	endfunction

	function automatic logic signed [tsvf_pkg::DATA_W-1:0] sat_out(
		input logic signed [tsvf_pkg::VAL_W-1:0] v
	);
		logic [tsvf_pkg::VAL_W-tsvf_pkg::DATA_W:0] top;
		top = v[tsvf_pkg::VAL_W-1:tsvf_pkg::DATA_W-1];
		if (top == '0 || top == '1) begin
			return v[tsvf_pkg::DATA_W-1:0];
		end else if (v[tsvf_pkg::VAL_W-1]) begin
			return {1'b1, {(tsvf_pkg::DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(tsvf_pkg::DATA_W-1){1'b1}}};
		end
	endfunction

	assign v3_in = tsvf_pkg::VAL_W'(sample_in) - tsvf_pkg::VAL_W'(s2_q);

	// MAC holds (sum of products + rounding) as {acc, low}
	assign res_coef  = tsvf_pkg::VAL_W'({mac_acc, mac_low[tsvf_pkg::LOW_W-1:tsvf_pkg::COEF_FRAC]});
	assign res_blend = tsvf_pkg::VAL_W'({mac_acc, mac_low[tsvf_pkg::LOW_W-1:tsvf_pkg::MORPH_FRAC]});

	assign int1_full = (INT_W'(v1_q) <<< 1) - INT_W'(s1_q);
	assign int2_full = (INT_W'(v2_q) <<< 1) - INT_W'(s2_q);

	assign m_clip  = (morph_q > tsvf_pkg::MORPH_W'(tsvf_pkg::MORPH_ONE))
	               ? tsvf_pkg::MORPH_W'(tsvf_pkg::MORPH_ONE) : morph_q;
	assign m_upper = (m_clip >= tsvf_pkg::MORPH_W'(tsvf_pkg::MORPH_HALF));
	assign t_w     = m_upper ? ((m_clip - tsvf_pkg::MORPH_W'(tsvf_pkg::MORPH_HALF)) << 1)
	                         : (m_clip << 1);
	assign w_a     = tsvf_pkg::MORPH_W'(tsvf_pkg::MORPH_ONE) - t_w;

	always_comb begin
		mac_req    = '0;
		mac_coef_a = '0;
		mac_coef_b = '0;
		mac_op_a   = '0;
		mac_op_b   = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mac_req.start = 1'b1;
					mac_coef_a    = a1_q;
					mac_op_a      = tsvf_pkg::VAL_W'(s1_q);
					mac_coef_b    = a2_q;
					mac_op_b      = v3_in;
				end
			end
			S_V1: begin
				if (mac_sts.done) begin
					mac_req.start = 1'b1;
					mac_coef_a    = a2_q;
					mac_op_a      = tsvf_pkg::VAL_W'(s1_q);
					mac_coef_b    = a3_q;
					mac_op_b      = v3_q;
				end
			end
			S_V2: begin
				if (mac_sts.done) begin
					mac_req.start = 1'b1;
					mac_coef_a    = k_q;
					mac_op_a      = v1_q;
				end
			end
			S_SEL: begin
				if (morph_en_q) begin
					mac_req.start = 1'b1;
					mac_req.blend = 1'b1;
					mac_coef_a    = tsvf_pkg::COEF_W'(w_a);
					mac_coef_b    = tsvf_pkg::COEF_W'(t_w);
					mac_op_a      = m_upper ? v1_q : v2_q;
					mac_op_b      = m_upper ? hp_q : v1_q;
				end
			end
			default: begin
			end
		endcase
	end

	tsvf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.coef_a (mac_coef_a),
		.coef_b (mac_coef_b),
		.op_a   (mac_op_a),
		.op_b   (mac_op_b),
		.sts    (mac_sts),
		.acc    (mac_acc),
		.low    (mac_low)
	);

	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// control, configuration and integrators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			a1_q        <= tsvf_pkg::A1_RST;
			a2_q        <= '0;
			a3_q        <= '0;
			k_q         <= tsvf_pkg::K_RST;
			mode_q      <= tsvf_pkg::MODE_LP;
			morph_en_q  <= 1'b0;
			morph_q     <= '0;
			s1_q        <= '0;
			s2_q        <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					tsvf_pkg::REG_COEF_A1:      a1_q       <= cfg_data[tsvf_pkg::COEF_W-1:0];
					tsvf_pkg::REG_COEF_A2:      a2_q       <= cfg_data[tsvf_pkg::COEF_W-1:0];
					tsvf_pkg::REG_COEF_A3:      a3_q       <= cfg_data[tsvf_pkg::COEF_W-1:0];
					tsvf_pkg::REG_DAMPING_K:    k_q        <= cfg_data[tsvf_pkg::COEF_W-1:0];
					tsvf_pkg::REG_FILTER_MODE:
						mode_q <= tsvf_pkg::tsvf_mode_t'(cfg_data[tsvf_pkg::MODE_W-1:0]);
					tsvf_pkg::REG_MORPH_ENABLE: morph_en_q <= cfg_data[0];
					tsvf_pkg::REG_MORPH_AMOUNT: morph_q    <= cfg_data[tsvf_pkg::MORPH_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_V1;
					end
				end
				S_V1: begin
					if (mac_sts.done) begin
						state_q <= S_V2;
					end
				end
				S_V2: begin
					if (mac_sts.done) begin
						state_q <= S_KV1;
					end
				end
				S_KV1: begin
					if (mac_sts.done) begin
						state_q <= S_HP;
					end
				end
				S_HP: begin
					s1_q    <= sat_state(int1_full);
					s2_q    <= sat_state(int2_full);
					state_q <= S_SEL;
				end
				S_SEL: begin
					state_q <= morph_en_q ? S_BLEND : S_OUT;
				end
				S_BLEND: begin
					if (mac_sts.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					x_q  <= sample_in;
					v3_q <= v3_in;
				end
			end
			S_V1: begin
				if (mac_sts.done) begin
					v1_q <= res_coef;
				end
			end
			S_V2: begin
				if (mac_sts.done) begin
					v2_q <= tsvf_pkg::VAL_W'(s2_q) + res_coef;
				end
			end
			S_KV1: begin
				if (mac_sts.done) begin
					notch_q <= tsvf_pkg::VAL_W'(x_q) - res_coef;
				end
			end
			S_HP: begin
				hp_q <= notch_q - v2_q;
			end
			S_SEL: begin
				case (mode_q)
					tsvf_pkg::MODE_LP:    y_q <= v2_q;
					tsvf_pkg::MODE_BP:    y_q <= v1_q;
					tsvf_pkg::MODE_HP:    y_q <= hp_q;
					tsvf_pkg::MODE_NOTCH: y_q <= notch_q;
					default:              y_q <= v2_q;
				endcase
			end
			S_BLEND: begin
				if (mac_sts.done) begin
					y_q <= res_blend;
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_q <= sat_out(y_q);
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	`TSVF_ASSERT_RST(a_rst_no_output, !arst_n |-> !out_valid, "output valid during reset")
	`TSVF_ASSERT(a_accept_starts_mac,
		(in_valid && !in_stall) |=> (state_q == S_V1 && mac_sts.busy),
		"accepted sample did not start the MAC")
	`TSVF_ASSERT(a_out_from_final, $rose(out_valid_q) |-> $past(state_q == S_OUT),
		"output raised outside final state")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// State variable filter testbench
// Feeds audio samples in random bursts against a randomly stalling receiver,
// predicts every filtered sample in fixed point and checks the output stream
// in order. Walks through all modes, morph positions and coefficient sets
// from well-damped filters to unstable and all-ones coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import tsvf_pkg::*;

	localparam logic [CFG_IDX_W-1:0]     REG_SPARE     = 3'd7;
	localparam logic signed [DATA_W-1:0] SAMPLE_MAX    = 24'sh7FFFFF;
	localparam logic signed [DATA_W-1:0] SAMPLE_MIN    = 24'sh800000;
	localparam logic [COEF_W-1:0]        COEF_MAX      = 24'hFFFFFF;
	localparam longint                   INTEG_MIN     = -64'sd2147483648;
	localparam longint                   INTEG_MAX     = 64'sd2147483647;
	localparam real                      Q22           = 4194304.0;
	localparam int                       RANDOM_PHASES = 12;
	localparam int                       PHASE_ITEMS   = 80;
	localparam int                       CYCLE_LIMIT   = 800000;
	localparam int                       TAIL_CYCLES   = 40;

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index  = '0;
	logic [CFG_DATA_W-1:0]       cfg_data   = '0;
	logic                        in_valid   = 1'b0;
	logic                        in_stall;
	logic signed [DATA_W-1:0]    sample_in  = '0;
	logic                        out_valid;
	logic                        out_stall  = 1'b0;
	logic signed [DATA_W-1:0]    sample_out;

	// filter configuration and integrators as the block should hold them
	longint     f_a1       = longint'(A1_RST);
	longint     f_a2       = 0;
	longint     f_a3       = 0;
	longint     f_k        = longint'(K_RST);
	tsvf_mode_t f_mode     = MODE_LP;
	logic       f_morph_en = 1'b0;
	longint     f_morph    = 0;
	int         integ_one  = 0;
	int         integ_two  = 0;

	logic signed [DATA_W-1:0] pending_samples[$];
	logic signed [DATA_W-1:0] expected_samples[$];

	int          err_cnt    = 0;
	int unsigned cycle_cnt  = 0;
	int          gap_left   = 0;
	int          burst_left = 1;
	int          hold_left  = 0;
	logic        held_once  = 1'b0;
	int          seg_left   = 0;
	int          stall_pct  = 0;

	tpt_state_variable_filter_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint round_q(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint crossfade(input longint a, input longint b, input longint t);
		return round_q((longint'(MORPH_ONE) - t) * a + t * b, MORPH_FRAC);
	endfunction

	// one trapezoidal SVF step; advances the integrators
	function automatic logic signed [DATA_W-1:0] filter_step(
			input logic signed [DATA_W-1:0] x_in);
		longint x, s1, s2, v1, v2, v3, notch, hp, y, m;
		x = x_in;
		s1 = integ_one;
		s2 = integ_two;
		v3 = x - s2;
		v1 = round_q(f_a1 * s1 + f_a2 * v3, COEF_FRAC);
		v2 = s2 + round_q(f_a2 * s1 + f_a3 * v3, COEF_FRAC);
		notch = x - round_q(f_k * v1, COEF_FRAC);
		hp = notch - v2;
		integ_one = int'(clip(2 * v1 - s1, INTEG_MIN, INTEG_MAX));
		integ_two = int'(clip(2 * v2 - s2, INTEG_MIN, INTEG_MAX));
		if (f_morph_en) begin
			m = (f_morph > MORPH_ONE) ? longint'(MORPH_ONE) : f_morph;
			if (m < MORPH_HALF)
				y = crossfade(v2, v1, 2 * m);
			else
				y = crossfade(v1, hp, 2 * (m - MORPH_HALF));
		end else begin
			case (f_mode)
				MODE_BP:    y = v1;
				MODE_HP:    y = hp;
				MODE_NOTCH: y = notch;
				default:    y = v2;
			endcase
		end
		return DATA_W'(clip(y, longint'(SAMPLE_MIN), longint'(SAMPLE_MAX)));
	endfunction

	function automatic logic signed [DATA_W-1:0] draw_sample(
			input logic signed [DATA_W-1:0] prev);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return DATA_W'($urandom);
		else if (sel < 7)
			return DATA_W'($urandom_range(0, 2000)) - 24'sd1000;
		else if (sel == 7)
			return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
		else
			return prev;
	endfunction

	function automatic logic [MORPH_W-1:0] draw_morph();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return MORPH_W'(MORPH_HALF);
			2:       return MORPH_W'(MORPH_ONE);
			3:       return MORPH_W'($urandom_range(MORPH_ONE + 1, 131071));
			default: return MORPH_W'($urandom_range(0, MORPH_ONE));
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] draw_edge_coef();
		case ($urandom_range(0, 2))
			0:       return '0;
			1:       return COEF_MAX;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_COEF_A1:      f_a1 = longint'(data);
			REG_COEF_A2:      f_a2 = longint'(data);
			REG_COEF_A3:      f_a3 = longint'(data);
			REG_DAMPING_K:    f_k = longint'(data);
			REG_FILTER_MODE:  f_mode = tsvf_mode_t'(data[MODE_W-1:0]);
			REG_MORPH_ENABLE: f_morph_en = data[0];
			REG_MORPH_AMOUNT: f_morph = longint'(data[MORPH_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// narrow registers get junk in the unused upper data bits
	task automatic set_filter(input logic [COEF_W-1:0] a1, a2, a3, k,
			input tsvf_mode_t mode, input logic en, input logic [MORPH_W-1:0] amt);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(REG_COEF_A1, a1);
		write_reg(REG_COEF_A2, a2);
		write_reg(REG_COEF_A3, a3);
		write_reg(REG_DAMPING_K, k);
		write_reg(REG_FILTER_MODE, {junk[CFG_DATA_W-1:MODE_W], mode});
		write_reg(REG_MORPH_ENABLE, {junk[CFG_DATA_W-1:1], en});
		write_reg(REG_MORPH_AMOUNT, {junk[CFG_DATA_W-1:MORPH_W], amt});
	endtask

	// coefficients from prewarped gain g and damping k
	task automatic design_filter(input real g, input real kd, input tsvf_mode_t mode,
			input logic en, input logic [MORPH_W-1:0] amt);
		real a1r;
		a1r = 1.0 / (1.0 + g * (g + kd));
		set_filter(COEF_W'($rtoi(a1r * Q22)), COEF_W'($rtoi(a1r * g * Q22)),
			COEF_W'($rtoi(a1r * g * g * Q22)), COEF_W'($rtoi(kd * Q22)), mode, en, amt);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0);
	endtask

	// sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_samples.push_back(filter_step(sample_in));
			if (!(in_valid && in_stall)) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_samples.size() != 0) begin
					in_valid <= 1'b1;
					sample_in <= pending_samples.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end else
						burst_left <= burst_left - 1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall density changes per segment, plus long hold-offs
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (pending_samples.size() > 8 &&
					(!held_once || $urandom_range(0, 999) == 0)) begin
				out_stall <= 1'b1;
				hold_left <= $urandom_range(60, 120);
				held_once <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					case ($urandom_range(0, 3))
						0:       stall_pct <= 0;
						1:       stall_pct <= 25;
						2:       stall_pct <= 50;
						default: stall_pct <= 90;
					endcase
					seg_left <= $urandom_range(5, 200);
				end else
					seg_left <= seg_left - 1;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin : out_check
		logic signed [DATA_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				if (err_cnt < 10)
					$display("unexpected output transaction: sample_out %0d", sample_out);
				err_cnt = err_cnt + 1;
			end else begin
				want = expected_samples.pop_front();
				if (sample_out !== want) begin
					if (err_cnt < 10)
						$display("sample_out mismatch: expected %0d, got %0d", want, sample_out);
					err_cnt = err_cnt + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic signed [DATA_W-1:0] last;
		int kind;
		last = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients
		pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, 24'sd0, -24'sd1};
		wait_drained();

		// out-of-range index must not disturb anything
		write_reg(REG_SPARE, COEF_MAX);
		design_filter(0.5, 1.0, MODE_LP, 1'b0, '0);
		pending_samples = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN};
		wait_drained();
		design_filter(0.5, 1.0, MODE_BP, 1'b0, '0);
		pending_samples = '{SAMPLE_MIN, SAMPLE_MAX};
		wait_drained();
		design_filter(0.5, 1.0, MODE_HP, 1'b0, '0);
		pending_samples = '{SAMPLE_MAX, 24'sd0};
		wait_drained();
		design_filter(1.0, 2.0, MODE_NOTCH, 1'b0, '0);
		pending_samples = '{SAMPLE_MIN, SAMPLE_MIN};
		wait_drained();

		// morph: both halves, the midpoint, the end and past the end
		design_filter(0.5, 1.0, MODE_LP, 1'b1, '0);
		pending_samples = '{SAMPLE_MAX};
		wait_drained();
		write_reg(REG_MORPH_AMOUNT, CFG_DATA_W'(16384));
		pending_samples = '{SAMPLE_MIN};
		wait_drained();
		write_reg(REG_MORPH_AMOUNT, CFG_DATA_W'(MORPH_HALF));
		pending_samples = '{SAMPLE_MAX};
		wait_drained();
		write_reg(REG_MORPH_AMOUNT, CFG_DATA_W'(49152));
		pending_samples = '{SAMPLE_MIN};
		wait_drained();
		write_reg(REG_MORPH_AMOUNT, CFG_DATA_W'(MORPH_ONE));
		pending_samples = '{SAMPLE_MAX};
		wait_drained();
		write_reg(REG_MORPH_AMOUNT, CFG_DATA_W'(131071));
		pending_samples = '{SAMPLE_MIN};
		wait_drained();

		// all-ones coefficients blow up the integrators and the output
		set_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, MODE_HP, 1'b0, '1);
		pending_samples = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX};
		wait_drained();
		set_filter('0, '0, '0, '0, MODE_NOTCH, 1'b0, '0);
		pending_samples = '{SAMPLE_MAX, 24'sd1};
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			kind = (p < 2) ? 8 + p : $urandom_range(0, 9);
			if (kind == 8)
				set_filter(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
					COEF_W'($urandom), tsvf_mode_t'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), draw_morph());
			else if (kind == 9)
				set_filter(draw_edge_coef(), draw_edge_coef(), draw_edge_coef(),
					draw_edge_coef(), tsvf_mode_t'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), draw_morph());
			else
				design_filter($urandom_range(1, 4000) / 1000.0,
					$urandom_range(20, 2000) / 1000.0, tsvf_mode_t'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), draw_morph());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				last = draw_sample(last);
				pending_samples.push_back(last);
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && expected_samples.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
